### hw/rtl/morus_pkg.sv
package morus_pkg;

    localparam int ROWS  = 5;
    localparam int LANES = 4;
    localparam int LANE_W = 32;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ENCRYPT = 1'b1;

    localparam int ROT0 = 5;
    localparam int ROT1 = 31;
    localparam int ROT2 = 7;
    localparam int ROT3 = 22;
    localparam int ROT4 = 13;

    typedef logic [LANES-1:0][LANE_W-1:0] t_row;
    typedef t_row [ROWS-1:0]              t_state;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  row_index;
        logic [1:0]  lane_index;
        logic [31:0] load_value;
        logic [63:0] msg_low;
        logic [63:0] msg_high;
    } t_in;

    typedef struct packed {
        logic [63:0] cipher_low;
        logic [63:0] cipher_high;
    } t_out;

    // Rotate one lane left by a fixed amount (1..31).
    function automatic logic [LANE_W-1:0] rotl(input logic [LANE_W-1:0] x, input int n);
        rotl = (x << n) | (x >> (LANE_W - n));
    endfunction

    // New lane i = old lane i-1.
    function automatic t_row lane_rot32(input t_row w);
        lane_rot32 = {w[2], w[1], w[0], w[3]};
    endfunction

    // Swap lanes 0,2 and 1,3.
    function automatic t_row lane_rot64(input t_row w);
        lane_rot64 = {w[1], w[0], w[3], w[2]};
    endfunction

    // New lane i = old lane i+1.
    function automatic t_row lane_rot96(input t_row w);
        lane_rot96 = {w[0], w[3], w[2], w[1]};
    endfunction

    function automatic t_row mix_row(input t_row d, input t_row x, input t_row a,
                                     input t_row b, input t_row m, input int n);
        t_row v;
        for (int i = 0; i < LANES; i++) begin
            v[i] = rotl(d[i] ^ x[i] ^ (a[i] & b[i]) ^ m[i], n);
        end
        mix_row = v;
    endfunction

endpackage

### hw/rtl/morus_round.sv
module morus_round (
    input  morus_pkg::t_state i_state,
    input  morus_pkg::t_row   i_msg,
    output morus_pkg::t_state o_state,
    output morus_pkg::t_row   o_cipher
);

    morus_pkg::t_row s0, s1, s2, s3, s4;
    morus_pkg::t_row a0, a1, a2, a3, a4;
    morus_pkg::t_row s3r, s4r, a0r, a1r, a2r;

    assign s0 = i_state[0];
    assign s1 = i_state[1];
    assign s2 = i_state[2];
    assign s3 = i_state[3];
    assign s4 = i_state[4];

    // Ciphertext from the state before the update.
    always_comb begin
        for (int i = 0; i < morus_pkg::LANES; i++) begin
            o_cipher[i] = i_msg[i] ^ s0[i] ^ (s2[i] & s3[i]);
        end
        o_cipher = o_cipher ^ morus_pkg::lane_rot96(s1);
    end

    assign a0  = morus_pkg::mix_row(s0, s3, s1, s2, '0, morus_pkg::ROT0);
    assign s3r = morus_pkg::lane_rot32(s3);
    assign a1  = morus_pkg::mix_row(s1, s4, s2, s3r, i_msg, morus_pkg::ROT1);
    assign s4r = morus_pkg::lane_rot64(s4);
    assign a2  = morus_pkg::mix_row(s2, a0, s3r, s4r, i_msg, morus_pkg::ROT2);
    assign a0r = morus_pkg::lane_rot96(a0);
    assign a3  = morus_pkg::mix_row(s3r, a1, s4r, a0r, i_msg, morus_pkg::ROT3);
    assign a1r = morus_pkg::lane_rot64(a1);
    assign a4  = morus_pkg::mix_row(s4r, a2, a0r, a1r, i_msg, morus_pkg::ROT4);
    assign a2r = morus_pkg::lane_rot32(a2);

    assign o_state[0] = a0r;
    assign o_state[1] = a1r;
    assign o_state[2] = a2r;
    assign o_state[3] = a3;
    assign o_state[4] = a4;

endmodule

### hw/rtl/morus_state_update_encrypt_top.sv
// An accepted transfer is held in the input stage and applied to the state when it retires;
// an encrypt transfer writes its ciphertext to the result register at that same edge.
// Throughput: one item per cycle unless an encrypt waits on a full, stalled result register.
// Reset (synchronous, active low): clear the 640-bit state to zero, empty both stages.
module morus_state_update_encrypt_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  morus_pkg::t_in   i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output morus_pkg::t_out  o_data
);

    // Input stage
    logic               r_in_valid;
    morus_pkg::t_in     r_in;

    // State and result stage
    morus_pkg::t_state  r_state;
    logic               r_out_valid;
    morus_pkg::t_out    r_out;

    morus_pkg::t_state  n_state;
    morus_pkg::t_row    round_cipher;
    morus_pkg::t_row    msg;

    logic out_free;     // result register empty or being taken this cycle
    logic adv;          // item in the input stage retires this cycle
    logic is_enc;
    logic take_in;

    assign msg = morus_pkg::t_row'({r_in.msg_high, r_in.msg_low});

    morus_round u_round (
        .i_state  (r_state),
        .i_msg    (msg),
        .o_state  (n_state),
        .o_cipher (round_cipher)
    );

    assign is_enc   = (r_in.cmd == morus_pkg::CMD_ENCRYPT);
    assign out_free = !r_out_valid || !i_stall;
    // A load never needs the result register, so it retires at once.
    assign adv      = r_in_valid && (!is_enc || out_free);
    assign o_stall  = r_in_valid && !adv;
    assign take_in  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the payload while the stage is stalled.
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            if (is_enc) begin
                r_state <= n_state;
            end else if (r_in.row_index < 3'(morus_pkg::ROWS)) begin
                // Drop loads to rows beyond the last.
                r_state[r_in.row_index][r_in.lane_index] <= r_in.load_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && is_enc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && is_enc) begin
            r_out.cipher_low  <= round_cipher[1:0];
            r_out.cipher_high <= round_cipher[3:2];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
